// ===== rtl/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants for the SHA-1 message digest block: word widths,
// initial chaining values and the control bundle for the message schedule.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int WORD_W  = 32;
  localparam int CNT_W   = 61;
  localparam int LEN_W   = 64;
  localparam int ROUNDS  = 80;
  localparam int RND_W   = $clog2(ROUNDS);
  localparam int NWORDS  = 16;
  localparam int POS_W   = 6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [4:0][WORD_W-1:0] hash_t;

  localparam hash_t INIT_H = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  typedef enum logic [2:0] {
    SCHED_HOLD,
    SCHED_BYTE,
    SCHED_PAD,
    SCHED_LEN,
    SCHED_SHIFT
  } sched_mode_t;

  typedef struct packed {
    sched_mode_t      mode;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic [LEN_W-1:0] len_bits;
  } sched_ctrl_t;

endpackage

// ===== rtl/sha1md_sched.sv =====
// ----------------------------------------------------------------------------
// sha1md_sched
// Block buffer and message schedule: 16 words loaded byte by byte, with padding
// or as a length-only block, then shifted once per round with the expanded word fed in.
// ----------------------------------------------------------------------------
module sha1md_sched (
  input  logic                           clk,
  input  sha1md_pkg::sched_ctrl_t        ctrl,
  output logic [sha1md_pkg::WORD_W-1:0]  word
);

  logic [sha1md_pkg::NWORDS-1:0][sha1md_pkg::WORD_W-1:0] w;
  logic [sha1md_pkg::NWORDS-1:0][sha1md_pkg::WORD_W-1:0] w_pad;
  logic [sha1md_pkg::WORD_W-1:0] mix;
  logic [sha1md_pkg::WORD_W-1:0] expand;

  assign mix    = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign expand = {mix[sha1md_pkg::WORD_W-2:0], mix[sha1md_pkg::WORD_W-1]};
  assign word   = w[0];

  // keep bytes before the marker, set the marker, zero the rest, add length if it fits
  always_comb begin
    logic [sha1md_pkg::POS_W-1:0] p;
    for (int i = 0; i < sha1md_pkg::NWORDS; i++) begin
      for (int j = 0; j < 4; j++) begin
        p = sha1md_pkg::POS_W'(4 * i + j);
        if (p < ctrl.pos) begin
          w_pad[i][31 - 8*j -: 8] = w[i][31 - 8*j -: 8];
        end else if (p == ctrl.pos) begin
          w_pad[i][31 - 8*j -: 8] = sha1md_pkg::PAD_BYTE;
        end else begin
          w_pad[i][31 - 8*j -: 8] = 8'h00;
        end
      end
    end
    if (ctrl.pos < sha1md_pkg::POS_W'(56)) begin
      w_pad[14] = ctrl.len_bits[63:32];
      w_pad[15] = ctrl.len_bits[31:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      sha1md_pkg::SCHED_BYTE: begin
        w[ctrl.pos[5:2]][31 - 8*ctrl.pos[1:0] -: 8] <= ctrl.data;
      end
      sha1md_pkg::SCHED_PAD: begin
        w <= w_pad;
      end
      sha1md_pkg::SCHED_LEN: begin
        for (int i = 0; i < sha1md_pkg::NWORDS - 2; i++) begin
          w[i] <= '0;
        end
        w[14] <= ctrl.len_bits[63:32];
        w[15] <= ctrl.len_bits[31:0];
      end
      sha1md_pkg::SCHED_SHIFT: begin
        for (int i = 0; i < sha1md_pkg::NWORDS - 1; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= expand;
      end
      default: begin
        w <= w;
      end
    endcase
  end

endmodule

// ===== rtl/sha1md_round.sv =====
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 compression round: round function, constant and the five-term
// add, shared by all 80 rounds of a block.
// ----------------------------------------------------------------------------
module sha1md_round (
  input  sha1md_pkg::hash_t              cur,
  input  logic [sha1md_pkg::WORD_W-1:0]  word,
  input  logic [sha1md_pkg::RND_W-1:0]   rnd,
  output sha1md_pkg::hash_t              nxt
);

  logic [31:0] a, b, c, d, e;
  logic [31:0] f;
  logic [31:0] k;

  assign a = cur[0];
  assign b = cur[1];
  assign c = cur[2];
  assign d = cur[3];
  assign e = cur[4];

  always_comb begin
    priority if (rnd < sha1md_pkg::RND_W'(20)) begin
      f = (b & c) | (~b & d);
      k = 32'h5A827999;
    end else if (rnd < sha1md_pkg::RND_W'(40)) begin
      f = b ^ c ^ d;
      k = 32'h6ED9EBA1;
    end else if (rnd < sha1md_pkg::RND_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
      k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d;
      k = 32'hCA62C1D6;
    end
  end

  assign nxt[0] = {a[26:0], a[31:27]} + f + e + k + word;
  assign nxt[1] = a;
  assign nxt[2] = {b[1:0], b[31:2]};
  assign nxt[3] = c;
  assign nxt[4] = d;

endmodule

// ===== rtl/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest
// Streams a message one byte per transfer and delivers its SHA-1 digest.
// ----------------------------------------------------------------------------
// Input: a byte that neither fills a block nor is last causes no stall; a byte
//   that fills a 64-byte block stalls the input while the single round unit runs
//   all rounds of the block and the chaining add follows.
// Last item: the digest follows one or two padded blocks, or a filled block and
//   one padded block if its byte fills a block.
// Reset: chaining words to initial values, byte count to zero, no digest pending.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_t;

  state_t                             state;
  sha1md_pkg::hash_t                  chain;
  sha1md_pkg::hash_t                  work;
  sha1md_pkg::hash_t                  work_next;
  logic [sha1md_pkg::CNT_W-1:0]       byte_count;
  logic [sha1md_pkg::RND_W-1:0]       rnd;
  logic                               pend_last;
  logic                               pad_started;
  logic                               len_done;
  logic [sha1md_pkg::WORD_W-1:0]      word;
  sha1md_pkg::sched_ctrl_t            sched_ctrl;
  logic                               in_xfer;
  logic                               block_full;
  logic                               out_free;

  assign in_stall   = (state != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign block_full = byte_valid && (byte_count[5:0] == 6'd63);
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    sched_ctrl.pos      = byte_count[5:0];
    sched_ctrl.data     = data_byte;
    sched_ctrl.len_bits = {byte_count, 3'b000};
    unique case (state)
      ST_IDLE:  sched_ctrl.mode = (in_xfer && byte_valid) ? sha1md_pkg::SCHED_BYTE
                                                          : sha1md_pkg::SCHED_HOLD;
      ST_ROUND: sched_ctrl.mode = sha1md_pkg::SCHED_SHIFT;
      ST_PAD:   sched_ctrl.mode = sha1md_pkg::SCHED_PAD;
      ST_LEN:   sched_ctrl.mode = sha1md_pkg::SCHED_LEN;
      default:  sched_ctrl.mode = sha1md_pkg::SCHED_HOLD;
    endcase
  end

  sha1md_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .word (word)
  );

  sha1md_round u_round (
    .cur  (work),
    .word (word),
    .rnd  (rnd),
    .nxt  (work_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      chain       <= sha1md_pkg::INIT_H;
      byte_count  <= '0;
      rnd         <= '0;
      pend_last   <= 1'b0;
      pad_started <= 1'b0;
      len_done    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // drop the accepted digest; in ST_EMIT a new one may take its place
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            pend_last   <= is_last;
            pad_started <= 1'b0;
            len_done    <= 1'b0;
            if (byte_valid) begin
              byte_count <= byte_count + 1'b1;
            end
            if (block_full) begin
              work  <= chain;
              rnd   <= '0;
              state <= ST_ROUND;
            end else if (is_last) begin
              state <= ST_PAD;
            end
          end
        end
        ST_ROUND: begin
          work <= work_next;
          rnd  <= rnd + 1'b1;
          if (rnd == sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS - 1)) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 5; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          priority if (!pend_last) begin
            state <= ST_IDLE;
          end else if (len_done) begin
            state <= ST_EMIT;
          end else if (pad_started) begin
            state <= ST_LEN;
          end else begin
            state <= ST_PAD;
          end
        end
        ST_PAD: begin
          // length fits behind the marker only if the marker sits below byte 56
          pad_started <= 1'b1;
          len_done    <= (byte_count[5:0] < 6'd56);
          work        <= chain;
          rnd         <= '0;
          state       <= ST_ROUND;
        end
        ST_LEN: begin
          len_done <= 1'b1;
          work     <= chain;
          rnd      <= '0;
          state    <= ST_ROUND;
        end
        ST_EMIT: begin
          // hold until the output register is free, then restart the message
          if (out_free) begin
            digest_word0 <= chain[0];
            digest_word1 <= chain[1];
            digest_word2 <= chain[2];
            digest_word3 <= chain[3];
            digest_word4 <= chain[4];
            out_valid    <= 1'b1;
            chain        <= sha1md_pkg::INIT_H;
            byte_count   <= '0;
            pend_last    <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND |-> rnd < sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS))
    else $error("round index out of range");

  a_last_latched: assert property (@(posedge clk) disable iff (rst)
    in_xfer && is_last |=> pend_last)
    else $error("last marker not held after transfer");

  a_emit_restart: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && out_free |=> out_valid && byte_count == '0 && state == ST_IDLE)
    else $error("digest transfer did not restart the message");

  a_len_before_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> len_done && pad_started)
    else $error("digest delivered before length block");

endmodule
